// ===== sv/ewas_pkg.sv =====
`timescale 1ns / 1ps

package ewas_pkg;

  localparam int unsigned UsW    = 48;
  localparam int unsigned SecW   = 40;
  localparam int unsigned LimW   = 32;
  localparam int unsigned RearmW = 20;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LimW-1:0]   TickPeriodRst = 32'd100000;
  localparam logic [LimW-1:0]   StageOneRst   = 32'd120000000;
  localparam logic [LimW-1:0]   GiveUpRst     = 32'd240000000;
  localparam logic [LimW-1:0]   PrewakeRst    = 32'd10000000;
  localparam logic [RearmW-1:0] RearmRst      = 20'd86400;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_ARM       = 3'd1,
    OP_SWITCHOFF = 3'd2,
    OP_PREWAKE   = 3'd3,
    OP_SET_ALARM = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_PRIMED      = 3'd1,
    MODE_RING        = 3'd2,
    MODE_ESC         = 3'd3,
    MODE_FAILED      = 3'd4,
    MODE_PRE_PRIMED  = 3'd5,
    MODE_PREWAKE_RUN = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STR_WEAK   = 2'd0,
    STR_STRONG = 2'd1
  } strength_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_PERIOD = 3'd0,
    CFG_STAGE_ONE   = 3'd1,
    CFG_GIVE_UP     = 3'd2,
    CFG_PREWAKE     = 3'd3,
    CFG_REARM       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]      operation;
    logic [UsW-1:0]  now_us;
    logic [SecW-1:0] now_seconds;
    logic            in_bed;
    logic [SecW-1:0] alarm_time;
    logic [1:0]      strength_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic            wake_drive;
    logic            vibe_level;
    logic            failure_report;
    logic [SecW-1:0] next_alarm_out;
    logic            strong_out;
    logic            acted;
  } out_item_t;

  typedef struct packed {
    logic [LimW-1:0]   tick_period_us;
    logic [LimW-1:0]   stage_one_us;
    logic [LimW-1:0]   give_up_us;
    logic [LimW-1:0]   prewake_us;
    logic [RearmW-1:0] rearm_seconds;
  } cfg_t;

  // True when now lies strictly more than lim beyond since.
  function automatic logic beyond(logic [UsW-1:0] now, logic [UsW-1:0] since,
                                  logic [LimW-1:0] lim);
    logic [UsW-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff > {{(UsW-LimW){1'b0}}, lim});
  endfunction

endpackage

// ===== sv/ewas_core.sv =====
`timescale 1ns / 1ps

module ewas_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ewas_pkg::in_item_t  item_i,
  input  ewas_pkg::cfg_t      cfg_i,
  output ewas_pkg::out_item_t res_o
);
  import ewas_pkg::*;

  mode_e           mode_q, mode_d;
  logic [UsW-1:0]  ring_start_q, ring_start_d;
  logic [UsW-1:0]  last_acted_q, last_acted_d;
  logic [SecW-1:0] alarm_q, alarm_d;
  logic            strong_q, strong_d;
  logic            drive_q, drive_d;
  logic            level_q, level_d;
  logic            acted;
  logic            report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      ring_start_q <= '0;
      last_acted_q <= '0;
      alarm_q      <= '0;
      strong_q     <= 1'b0;
      drive_q      <= 1'b0;
      level_q      <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      ring_start_q <= ring_start_d;
      last_acted_q <= last_acted_d;
      alarm_q      <= alarm_d;
      strong_q     <= strong_d;
      drive_q      <= drive_d;
      level_q      <= level_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    ring_start_d = ring_start_q;
    last_acted_d = last_acted_q;
    alarm_d      = alarm_q;
    strong_d     = strong_q;
    drive_d      = drive_q;
    level_d      = level_q;
    acted        = 1'b0;
    report       = 1'b0;
    case (op_e'(item_i.operation))
      OP_TICK: begin
        if (beyond(item_i.now_us, last_acted_q, cfg_i.tick_period_us)) begin
          last_acted_d = item_i.now_us;
          acted        = 1'b1;
          case (mode_q)
            MODE_OFF: begin
              if (alarm_q < item_i.now_seconds) begin
                mode_d  = strong_q ? MODE_PRE_PRIMED : MODE_PRIMED;
                alarm_d = alarm_q + {{(SecW-RearmW){1'b0}}, cfg_i.rearm_seconds};
              end
            end
            MODE_PRIMED: begin
              if (item_i.in_bed) begin
                mode_d       = MODE_RING;
                ring_start_d = item_i.now_us;
                drive_d      = 1'b1;
                level_d      = 1'b0;
              end else begin
                mode_d  = MODE_OFF;
                drive_d = 1'b0;
              end
            end
            MODE_RING: begin
              if (!item_i.in_bed) begin
                mode_d  = MODE_OFF;
                drive_d = 1'b0;
              end else if (beyond(item_i.now_us, ring_start_q, cfg_i.stage_one_us)) begin
                level_d = 1'b1;
                mode_d  = MODE_ESC;
              end
            end
            MODE_ESC: begin
              if (!item_i.in_bed) begin
                mode_d  = MODE_OFF;
                drive_d = 1'b0;
              end else if (beyond(item_i.now_us, ring_start_q, cfg_i.give_up_us)) begin
                mode_d  = MODE_FAILED;
                drive_d = 1'b0;
              end
            end
            MODE_FAILED: begin
              report = 1'b1;
              mode_d = MODE_OFF;
            end
            MODE_PRE_PRIMED: begin
              if (item_i.in_bed) begin
                mode_d       = MODE_PREWAKE_RUN;
                ring_start_d = item_i.now_us;
                drive_d      = 1'b1;
                level_d      = 1'b0;
              end else begin
                mode_d = MODE_OFF;
              end
            end
            MODE_PREWAKE_RUN: begin
              if (beyond(item_i.now_us, ring_start_q, cfg_i.prewake_us)) begin
                mode_d  = MODE_OFF;
                drive_d = 1'b0;
              end
            end
            default: begin
              mode_d = MODE_OFF;
            end
          endcase
        end
      end
      OP_ARM: begin
        mode_d = MODE_PRIMED;
      end
      OP_SWITCHOFF: begin
        drive_d = 1'b0;
        mode_d  = MODE_OFF;
      end
      OP_PREWAKE: begin
        mode_d = MODE_PREWAKE_RUN;
      end
      OP_SET_ALARM: begin
        alarm_d = item_i.alarm_time;
        if (strength_e'(item_i.strength_code) == STR_WEAK) begin
          strong_d = 1'b0;
        end else if (strength_e'(item_i.strength_code) == STR_STRONG) begin
          strong_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_o.mode           = mode_d;
    res_o.wake_drive     = drive_d;
    res_o.vibe_level     = level_d;
    res_o.failure_report = report;
    res_o.next_alarm_out = alarm_d;
    res_o.strong_out     = strong_d;
    res_o.acted          = acted;
  end

  a_fail_goes_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.failure_report |=> mode_q == MODE_OFF)
    else $error("failure report did not return the mode to off");

  a_cmd_not_acted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_e'(item_i.operation) != OP_TICK |-> !res_o.acted && !res_o.failure_report)
    else $error("command reported acted or failure");

  a_last_acted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.acted |=> last_acted_q == $past(item_i.now_us))
    else $error("acted tick did not record its time");

  a_failed_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_FAILED |-> !drive_q)
    else $error("wake drive enabled in failed mode");

endmodule

// ===== sv/escalating_wake_alarm_sequencer.sv =====
`timescale 1ns / 1ps

// Escalating wake alarm sequencer.
// Input channel (in_valid_i, in_ready_o, in_data_i): one transaction is either
// a tick carrying monotonic microseconds, wall-clock seconds and the in-bed
// flag, or a command (arm, switch off, prewake, set alarm time and strength).
// Output channel (out_valid_o, out_ready_i, out_data_o): every input
// transaction yields exactly one result transaction, in order, carrying the
// mode, wake drive, vibe level, failure pulse, alarm time, strength and the
// acted flag of the tick gate.
// Configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// writes the five timing registers; it is always ready and is to be used only
// while no transaction is in flight. Unknown indexes are ignored.
// An accepted transaction is held in an input register, evaluated against the
// alarm state and written to the result register, which presents it; while
// the receiver does not stall, one transaction per cycle is sustained. When
// the receiver stalls, the result register holds and the input register
// keeps one more transaction before in_ready_o drops.
// Reset clears the alarm state to off and loads the register defaults.
module escalating_wake_alarm_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ewas_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ewas_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ewas_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ewas_pkg::LimW-1:0]          cfg_data_i
);
  import ewas_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_us <= TickPeriodRst;
      cfg_q.stage_one_us   <= StageOneRst;
      cfg_q.give_up_us     <= GiveUpRst;
      cfg_q.prewake_us     <= PrewakeRst;
      cfg_q.rearm_seconds  <= RearmRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TICK_PERIOD: cfg_q.tick_period_us <= cfg_data_i;
        CFG_STAGE_ONE:   cfg_q.stage_one_us   <= cfg_data_i;
        CFG_GIVE_UP:     cfg_q.give_up_us     <= cfg_data_i;
        CFG_PREWAKE:     cfg_q.prewake_us     <= cfg_data_i;
        CFG_REARM:       cfg_q.rearm_seconds  <= cfg_data_i[RearmW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  ewas_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated transaction did not reach the result register");

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held input transaction was lost");

endmodule
